// File: hw/rtl/hta_pkg.sv
// Shared types and constants for the handle table allocator.
package hta_pkg;

  // Request codes.
  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_MAP     = 2'd2,
    OP_UNLOCK  = 2'd3
  } op_e;

  // Result codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BUSY     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Fixed widths of the word fields, and the bit position of the lock flag.
  localparam int unsigned WordW      = 32;
  localparam int unsigned HandleOutW = 12;
  localparam int unsigned LiveW      = 13;
  localparam int unsigned LockBit    = 31;

  // Request word.
  typedef struct packed {
    op_e               opcode;
    logic [WordW-1:0]  handle;
    logic [WordW-1:0]  object_value;
    logic [WordW-1:0]  access_value;
  } req_t;

  // Result word.
  typedef struct packed {
    status_e                status;
    logic [HandleOutW-1:0]  handle_out;
    logic [WordW-1:0]       object_out;
    logic [WordW-1:0]       access_out;
    logic [LiveW-1:0]       live_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/handle_table_allocator_top.sv
// Top level of the handle table allocator: controller, datapath and their wiring.
//
//  channel  direction  word            handshake
//  in       input      hta_pkg::req_t  in_valid_i / in_stall_o
//  out      output     hta_pkg::rsp_t  out_valid_o / out_stall_i
//
// Each request passes through capture, a registered read of both table memories,
// then execute with the table writes, which also registers its result word.
// The next request is accepted in the cycle after execute, so a new request is
// not taken before the last one is through; execute waits while a stalled result
// word still sits in the output register.
// Reset is asynchronous; it clears the free list pointers, counters, output valid
// flag and FSM state; tables need no clearing, as a bump pointer serves fresh pages.
module handle_table_allocator_top #(
  parameter int unsigned PAGE_ENTRIES  = 512,
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hta_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hta_pkg::rsp_t out_data_o
);

  hta_pkg::cmd_t  cmd;
  hta_pkg::stat_t stat;

  // Sequencing.
  hta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table storage and request execution.
  hta_datapath #(
    .PAGE_ENTRIES  (PAGE_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// File: hw/rtl/hta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hta_ctrl.sv
// Controller state machine that sequences capture, table read and execute.
module hta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hta_pkg::stat_t stat_i,
  output hta_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   stall_q;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.capture = in_valid_i;
      S_READ: cmd_o.read    = 1'b1;
      S_EXEC: cmd_o.exec    = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // State and the registered input stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_READ;
            stall_q <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

// File: hw/rtl/hta_datapath.sv
// Datapath: request register, table memories, free list pointers and output register.
module hta_datapath #(
  parameter int unsigned PAGE_ENTRIES  = 512,
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hta_pkg::req_t  in_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output hta_pkg::rsp_t  out_data_o,
  input  hta_pkg::cmd_t  cmd_i,
  output hta_pkg::stat_t stat_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PtrW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WordW = hta_pkg::WordW;
  localparam logic [PtrW-1:0]  NoEntry  = PtrW'(TABLE_ENTRIES);
  localparam logic [WordW-1:0] TableW   = WordW'(TABLE_ENTRIES);
  localparam logic [WordW-1:0] PageW    = WordW'(PAGE_ENTRIES);
  localparam logic [WordW-1:0] LockMask = WordW'(1) << hta_pkg::LockBit;

  hta_pkg::req_t req_q;
  hta_pkg::rsp_t out_q, rsp_d;
  logic          out_valid_q;

  logic [PtrW-1:0] free_head_q, free_head_d;
  logic [PtrW-1:0] hw_q, hw_d;
  logic [PtrW-1:0] fresh_q, fresh_d;
  logic [PtrW-1:0] count_q, count_d;

  logic [WordW-1:0] obj_rd, acc_rd;
  logic             obj_we, acc_we;
  logic [PtrW-1:0]  wr_idx;
  logic [WordW-1:0] obj_wdata, acc_wdata;
  logic [IdxW-1:0]  rd_addr;

  // Allocation choice for a create.
  logic             head_valid, head_fresh, use_list, can_alloc;
  logic [PtrW-1:0]  alloc_idx, alloc_next, fresh_limit, fresh_head, link_next, page_end;
  logic [WordW-1:0] page_sum, alloc32, count32, obj_clr;
  logic             found;
  logic [PtrW-1:0]  hnd_idx;

  // Table memories: object words and link-or-access words.
  hta_ram #(.WIDTH(WordW), .DEPTH(TABLE_ENTRIES)) u_obj_ram (
    .clk_i   (clk_i),
    .we_i    (obj_we && cmd_i.exec),
    .waddr_i (wr_idx[IdxW-1:0]),
    .wdata_i (obj_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (rd_addr),
    .rdata_o (obj_rd)
  );

  hta_ram #(.WIDTH(WordW), .DEPTH(TABLE_ENTRIES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we && cmd_i.exec),
    .waddr_i (wr_idx[IdxW-1:0]),
    .wdata_i (acc_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (rd_addr),
    .rdata_o (acc_rd)
  );

  // A create reads at the free list head, the other requests at the handle.
  assign rd_addr = (req_q.opcode == hta_pkg::OP_CREATE) ? free_head_q[IdxW-1:0]
                                                          : req_q.handle[IdxW-1:0];

  // Entries from fresh_q up to the high-water mark form the untouched tail of the
  // free chain, so they are never written and are served by a bump pointer.
  assign head_valid  = free_head_q < NoEntry;
  assign head_fresh  = head_valid && (free_head_q == fresh_q);
  assign use_list    = head_valid && !head_fresh;
  assign can_alloc   = head_valid || (hw_q < NoEntry);
  assign page_sum    = WordW'(hw_q) + PageW;
  assign page_end    = (page_sum > TableW) ? NoEntry : page_sum[PtrW-1:0];
  assign alloc_idx   = use_list ? free_head_q : (head_valid ? fresh_q : hw_q);
  assign alloc_next  = alloc_idx + PtrW'(1);
  assign fresh_limit = head_valid ? hw_q : page_end;
  assign fresh_head  = (alloc_next < fresh_limit) ? alloc_next : NoEntry;
  assign link_next   = (acc_rd < TableW) ? acc_rd[PtrW-1:0] : NoEntry;
  assign alloc32     = WordW'(alloc_idx);
  assign obj_clr     = req_q.object_value & ~LockMask;

  // Lookup: only entries handed out so far can hold a nonzero object word.
  assign found   = (req_q.handle < WordW'(fresh_q)) && (obj_rd != '0);
  assign hnd_idx = req_q.handle[PtrW-1:0];
  assign count32 = WordW'(count_d);

  // Execute one request.
  always_comb begin
    obj_we      = 1'b0;
    acc_we      = 1'b0;
    wr_idx      = hnd_idx;
    obj_wdata   = '0;
    acc_wdata   = '0;
    free_head_d = free_head_q;
    hw_d        = hw_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    rsp_d.status     = hta_pkg::ST_OK;
    rsp_d.handle_out = req_q.handle[hta_pkg::HandleOutW-1:0];
    rsp_d.object_out = '0;
    rsp_d.access_out = '0;
    case (req_q.opcode)
      hta_pkg::OP_CREATE: begin
        rsp_d.handle_out = '0;
        if (count_q >= NoEntry) begin
          rsp_d.status = hta_pkg::ST_FULL;
        end else if (obj_clr == '0) begin
          rsp_d.status = hta_pkg::ST_NOTFOUND;
        end else if (!can_alloc) begin
          rsp_d.status = hta_pkg::ST_FULL;
        end else begin
          obj_we    = 1'b1;
          acc_we    = 1'b1;
          wr_idx    = alloc_idx;
          obj_wdata = obj_clr;
          acc_wdata = req_q.access_value;
          count_d   = count_q + PtrW'(1);
          rsp_d.handle_out = alloc32[hta_pkg::HandleOutW-1:0];
          if (use_list) begin
            free_head_d = link_next;
          end else begin
            free_head_d = fresh_head;
            fresh_d     = alloc_next;
            if (!head_valid) begin
              hw_d = page_end;
            end
          end
        end
      end
      hta_pkg::OP_DESTROY: begin
        if (!found) begin
          rsp_d.status = hta_pkg::ST_NOTFOUND;
        end else if (obj_rd[hta_pkg::LockBit]) begin
          rsp_d.status = hta_pkg::ST_BUSY;
        end else begin
          obj_we      = 1'b1;
          acc_we      = 1'b1;
          obj_wdata   = '0;
          acc_wdata   = WordW'(free_head_q);
          free_head_d = hnd_idx;
          count_d     = count_q - PtrW'(1);
        end
      end
      hta_pkg::OP_MAP: begin
        if (!found) begin
          rsp_d.status = hta_pkg::ST_NOTFOUND;
        end else if (obj_rd[hta_pkg::LockBit]) begin
          rsp_d.status = hta_pkg::ST_BUSY;
        end else begin
          obj_we           = 1'b1;
          obj_wdata        = obj_rd | LockMask;
          rsp_d.object_out = obj_rd | LockMask;
          rsp_d.access_out = acc_rd;
        end
      end
      hta_pkg::OP_UNLOCK: begin
        if (!found) begin
          rsp_d.status = hta_pkg::ST_NOTFOUND;
        end else begin
          obj_we    = 1'b1;
          obj_wdata = obj_rd & ~LockMask;
        end
      end
      default: begin
        rsp_d.status = hta_pkg::ST_NOTFOUND;
      end
    endcase
    rsp_d.live_count = count32[hta_pkg::LiveW-1:0];
  end

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // Free list pointers and live count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= NoEntry;
      hw_q        <= '0;
      fresh_q     <= '0;
      count_q     <= '0;
    end else if (cmd_i.exec) begin
      free_head_q <= free_head_d;
      hw_q        <= hw_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
    end
  end

  // Output register: holds the result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // The bump pointer never passes the high-water mark.
  a_fresh_le_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= hw_q)
    else $error("fresh pointer above high-water mark");

  // The free head is a table entry or the empty marker.
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NoEntry)
    else $error("free head out of range");

  // Every handle in use was handed out below the bump pointer.
  a_count_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fresh_q)
    else $error("live count exceeds allocated entries");

  // An executed request always leaves a result word waiting.
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("result word lost after execute");

endmodule

// File: dv/handle_table_allocator_checker.sv
// Checker for the handle table allocator: predicts each result word and compares it.
`timescale 1ns / 100ps

module handle_table_allocator_checker #(
  parameter int unsigned PAGE_ENTRIES  = 512,
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  hta_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  hta_pkg::rsp_t out_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  localparam int unsigned EmptyMark = TABLE_ENTRIES;
  localparam int unsigned MaxReports = 10;

  // Shadow copy of the handle table and its free list.
  logic [hta_pkg::WordW-1:0] obj_mem  [TABLE_ENTRIES];
  logic [hta_pkg::WordW-1:0] link_mem [TABLE_ENTRIES];
  int unsigned free_head_q = EmptyMark;
  int unsigned water_mark = 0;
  int unsigned live_handles = 0;

  // Result words predicted but not yet seen on the output channel.
  hta_pkg::rsp_t expected_q[$];
  int unsigned mismatches = 0;

  // Allocate a handle: pop the free list, or open the next page at the water mark.
  function automatic hta_pkg::status_e allocate_handle(
      input logic [hta_pkg::WordW-1:0] obj_word,
      input logic [hta_pkg::WordW-1:0] acc_word,
      output logic [hta_pkg::HandleOutW-1:0] h_out);
    int unsigned h;
    int unsigned page_end;
    int unsigned i;
    h_out = '0;
    if (live_handles >= TABLE_ENTRIES) return hta_pkg::ST_FULL;
    obj_word[hta_pkg::LockBit] = 1'b0;
    // An empty object word could never be looked up again.
    if (obj_word == '0) return hta_pkg::ST_NOTFOUND;
    if (free_head_q < TABLE_ENTRIES) begin
      h = free_head_q;
      // A link at or past the end of the table ends the list.
      free_head_q = (link_mem[h] < TABLE_ENTRIES) ? link_mem[h] : EmptyMark;
    end else begin
      if (water_mark >= TABLE_ENTRIES) return hta_pkg::ST_FULL;
      h = water_mark;
      page_end = h + PAGE_ENTRIES;
      if (page_end > TABLE_ENTRIES) page_end = TABLE_ENTRIES;
      // The rest of the new page is chained in ascending order.
      for (i = h + 1; i < page_end; i++) begin
        obj_mem[i] = '0;
        link_mem[i] = (i + 1 < page_end) ? i + 1 : EmptyMark;
      end
      free_head_q = (h + 1 < page_end) ? h + 1 : EmptyMark;
      water_mark = page_end;
    end
    obj_mem[h] = obj_word;
    link_mem[h] = acc_word;
    live_handles++;
    h_out = h[hta_pkg::HandleOutW-1:0];
    return hta_pkg::ST_OK;
  endfunction

  // Work out the result word of one request and update the shadow table.
  function automatic hta_pkg::rsp_t predict_result(input hta_pkg::req_t r);
    hta_pkg::rsp_t res;
    logic [hta_pkg::WordW-1:0] cur;
    logic [hta_pkg::HandleOutW-1:0] h_new;
    int unsigned idx;
    res = '0;
    res.handle_out = r.handle[hta_pkg::HandleOutW-1:0];
    if (r.opcode == hta_pkg::OP_CREATE) begin
      res.status = allocate_handle(r.object_value, r.access_value, h_new);
      res.handle_out = h_new;
    end else if (r.handle >= water_mark || r.handle >= TABLE_ENTRIES) begin
      res.status = hta_pkg::ST_NOTFOUND;
    end else begin
      idx = r.handle;
      cur = obj_mem[idx];
      if (cur == '0) begin
        res.status = hta_pkg::ST_NOTFOUND;
      end else if (r.opcode == hta_pkg::OP_UNLOCK) begin
        obj_mem[idx][hta_pkg::LockBit] = 1'b0;
        res.status = hta_pkg::ST_OK;
      end else if (cur[hta_pkg::LockBit]) begin
        res.status = hta_pkg::ST_BUSY;
      end else if (r.opcode == hta_pkg::OP_DESTROY) begin
        obj_mem[idx] = '0;
        link_mem[idx] = free_head_q;
        free_head_q = idx;
        live_handles--;
        res.status = hta_pkg::ST_OK;
      end else begin
        cur[hta_pkg::LockBit] = 1'b1;
        obj_mem[idx] = cur;
        res.object_out = cur;
        res.access_out = link_mem[idx];
        res.status = hta_pkg::ST_OK;
      end
    end
    res.live_count = live_handles[hta_pkg::LiveW-1:0];
    return res;
  endfunction

  // Compare the result word first, then record the request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : check_words
    hta_pkg::rsp_t want;
    if (!rst_ni) begin
      free_head_q = EmptyMark;
      water_mark = 0;
      live_handles = 0;
      expected_q.delete();
      pending_o <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result word with none expected: %h", $time, out_data_i);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.handle_out !== want.handle_out ||
              out_data_i.object_out !== want.object_out ||
              out_data_i.access_out !== want.access_out ||
              out_data_i.live_count !== want.live_count) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: mismatch (expected/actual) status %0d/%0d handle %h/%h",
                       $time, want.status, out_data_i.status, want.handle_out,
                       out_data_i.handle_out,
                       "\n  object %h/%h access %h/%h live %0d/%0d",
                       want.object_out, out_data_i.object_out, want.access_out,
                       out_data_i.access_out, want.live_count, out_data_i.live_count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_data_i));
      pending_o <= expected_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: dv/tb_handle_table_allocator_top.sv
// Testbench top for the handle table allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_handle_table_allocator_top;

  localparam int unsigned PAGE_ENTRIES  = 512;
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned RandomWords   = 660;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 20;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  hta_pkg::req_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  hta_pkg::rsp_t  out_data;
  logic  calm = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  handle_table_allocator_top #(
    .PAGE_ENTRIES (PAGE_ENTRIES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  handle_table_allocator_checker #(
    .PAGE_ENTRIES (PAGE_ENTRIES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver stalls at random, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 35);
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, with random idle cycles ahead of it, and hold it until taken.
  task automatic issue_word(input hta_pkg::op_e op,
                            input logic [hta_pkg::WordW-1:0] h,
                            input logic [hta_pkg::WordW-1:0] obj,
                            input logic [hta_pkg::WordW-1:0] acc);
    hta_pkg::req_t w;
    w.opcode = op;
    w.handle = h;
    w.object_value = obj;
    w.access_value = acc;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly small handles that are likely live, some wide and some at the table edges.
  function automatic logic [hta_pkg::WordW-1:0] pick_handle();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) return $urandom_range(47);
    if (sel < 90) return $urandom();
    case ($urandom_range(5))
      0:       return 32'd511;
      1:       return 32'd512;
      2:       return 32'd4095;
      3:       return 32'd4096;
      4:       return 32'hFFFF_FFFF;
      default: return 32'h0000_1001;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned pick;
    hta_pkg::op_e op;
    logic [hta_pkg::WordW-1:0] obj;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lookups on an empty table, empty object words, locking and free-list order.
    issue_word(hta_pkg::OP_MAP, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_UNLOCK, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_0000, 32'h0000_1234);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h8000_0000, 32'h0000_0001);
    issue_word(hta_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_0001, 32'h0000_0000);
    issue_word(hta_pkg::OP_MAP, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_UNLOCK, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_UNLOCK, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd0, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd511, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd512, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'hFFFF_FFFF, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'h0000_1001, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd1, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_0002, 32'h5A5A_A5A5);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h8000_0003, 32'h0000_0003);
    issue_word(hta_pkg::OP_UNLOCK, 32'h0000_1001, 32'd0, 32'd0);

    // Random mix, with a calm stretch where neither side idles.
    for (n = 0; n < RandomWords; n++) begin
      calm <= (n >= 250 && n < 400);
      pick = $urandom_range(99);
      if (pick < 35) op = hta_pkg::OP_CREATE;
      else if (pick < 55) op = hta_pkg::OP_DESTROY;
      else if (pick < 80) op = hta_pkg::OP_MAP;
      else op = hta_pkg::OP_UNLOCK;
      obj = $urandom();
      if ($urandom_range(31) == 0) obj = $urandom_range(1) ? 32'h8000_0000 : 32'h0;
      issue_word(op, pick_handle(), obj, $urandom());
    end
    calm <= 1'b0;

    // Lookups around the page and table edges, then refill through the free list.
    issue_word(hta_pkg::OP_DESTROY, 32'd4095, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd2048, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd2048, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd512, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_0512, 32'hFFFF_0000);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_4095, 32'h0000_FFFF);
    issue_word(hta_pkg::OP_CREATE, 32'd0, 32'h0000_0001, 32'h0000_0001);
    issue_word(hta_pkg::OP_UNLOCK, 32'd2048, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_DESTROY, 32'd2048, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'h0000_1FFF, 32'd0, 32'd0);
    issue_word(hta_pkg::OP_MAP, 32'd4095, 32'd0, 32'd0);
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles for stray words.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hta_pkg.sv
hw/rtl/hta_ram.sv
hw/rtl/hta_ctrl.sv
hw/rtl/hta_datapath.sv
hw/rtl/handle_table_allocator_top.sv
dv/handle_table_allocator_checker.sv
dv/tb_handle_table_allocator_top.sv
